// ----- rtl/mpfs_pkg.sv -----
// ----------------------------------------------------------------------------
// mpfs_pkg
// Shared types and command codes for the multilevel priority FIFO scheduler.
// ----------------------------------------------------------------------------
package mpfs_pkg;

  // queue geometry, fixed by the result field widths
  localparam int LEVELS      = 7;
  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 6;

  typedef enum logic [1:0] {
    CMD_SCHEDULE = 2'd0,
    CMD_POP      = 2'd1,
    CMD_REMOVE   = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_READ  = 5'b00010,
    ST_POP   = 5'b00100,
    ST_RSCAN = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

endpackage

// ----- rtl/mpfs_ram.sv -----
// ----------------------------------------------------------------------------
// mpfs_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module mpfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/multilevel_priority_fifo_scheduler_top.sv -----
// ----------------------------------------------------------------------------
// multilevel_priority_fifo_scheduler_top
// Run queues of thread ids, one circular FIFO per priority level in a RAM.
// ----------------------------------------------------------------------------
// Usage: a command word is taken when start is high and busy is low.
// cmd 0 appends in_thread_id to the queue of the clamped priority level,
// cmd 1 pops the head of the highest non-empty level, cmd 2 deletes every
// copy of an id from all levels keeping order, cmd 3 only reports the count.
// Each command gives one result word, marked by out_valid for one cycle;
// busy stays high through that cycle, so no command word is taken at the edge
// that ends it.
// Pop does one RAM read of the head; remove walks every stored entry of all
// levels through the single RAM read port, compacting in place.
// The queue RAM is one read and one write port; each level keeps head and
// count registers, so no clearing pass is needed after reset: all counts
// reset to zero and the block is ready at once. The receiver cannot stall;
// each result is shown exactly once.
// ----------------------------------------------------------------------------
module multilevel_priority_fifo_scheduler_top
  import mpfs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_cmd,
  input  logic [ID_BITS-1:0] in_thread_id,
  input  logic signed [7:0]  in_priority_req,
  output logic               out_valid,
  output logic               out_found,
  output logic [ID_BITS-1:0] out_thread_out,
  output logic [6:0]         out_removed_count,
  output logic               out_overflow,
  output logic [6:0]         out_pending_count
);

  localparam int LW = $clog2(LEVELS);
  localparam int DW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = $clog2(LEVELS * QUEUE_DEPTH);

  // per-level circular buffer pointers
  logic [DW-1:0] head_r [LEVELS];
  logic [CW-1:0] cnt_r  [LEVELS];
  logic [6:0]    pend_r;

  state_t            st_r;
  cmd_t              cmd_r;
  logic [ID_BITS-1:0] id_r;
  logic [LW-1:0]     lvl_r;
  logic [CW-1:0]     idx_r;   // read index within current level
  logic [CW-1:0]     wcnt_r;  // kept entries in current level
  logic [6:0]        rem_r;
  logic              rvld_r;  // a read was issued last cycle
  logic [DW-1:0]     rpos_r;  // offset field, never assigned or read

  logic              accept;
  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [ID_BITS-1:0] wdata, rdata;

  mpfs_ram #(.WIDTH(ID_BITS), .DEPTH(LEVELS * QUEUE_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // command word handshake
  assign accept = start && !busy;

  // clamp of the requested priority to a level index
  logic [LW-1:0] clamp_lvl;
  always_comb begin
    if (in_priority_req < 8'sd1) begin
      clamp_lvl = '0;
    end else if (in_priority_req > 8'(LEVELS)) begin
      clamp_lvl = LW'(LEVELS - 1);
    end else begin
      clamp_lvl = LW'(in_priority_req - 8'sd1);
    end
  end

  // highest non-empty level
  logic          any_q;
  logic [LW-1:0] top_lvl;
  always_comb begin
    any_q   = 1'b0;
    top_lvl = '0;
    for (int l = 0; l < LEVELS; l++) begin
      if (cnt_r[l] != '0) begin
        any_q   = 1'b1;
        top_lvl = LW'(l);
      end
    end
  end

  function automatic logic [AW-1:0] addr_of(logic [LW-1:0] l, logic [DW-1:0] off);
    logic [AW:0] a;
    a = (AW+1)'(l) * (AW+1)'(QUEUE_DEPTH) + (AW+1)'(off);
    return a[AW-1:0];
  endfunction

  logic [DW-1:0] cur_head;
  logic [CW-1:0] cur_cnt;
  assign cur_head = head_r[lvl_r];
  assign cur_cnt  = cnt_r[lvl_r];

  // memory port control
  always_comb begin
    we    = 1'b0;
    waddr = addr_of(clamp_lvl, DW'(head_r[clamp_lvl] + DW'(cnt_r[clamp_lvl])));
    wdata = in_thread_id;
    raddr = addr_of(lvl_r, DW'(cur_head + DW'(idx_r)));
    if (st_r == ST_IDLE) begin
      we = accept && (cmd_t'(in_cmd) == CMD_SCHEDULE) &&
           (cnt_r[clamp_lvl] < CW'(QUEUE_DEPTH));
      raddr = addr_of(top_lvl, head_r[top_lvl]);
    end else if (st_r == ST_RSCAN) begin
      waddr = addr_of(lvl_r, DW'(cur_head + DW'(wcnt_r)));
      wdata = rdata;
      we    = rvld_r && (rdata != id_r);
    end
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      pend_r    <= '0;
      out_valid <= 1'b0;
      rvld_r    <= 1'b0;
      for (int l = 0; l < LEVELS; l++) begin
        head_r[l] <= '0;
        cnt_r[l]  <= '0;
      end
    end else begin
      out_valid <= 1'b0;
      unique case (st_r)
        ST_IDLE: begin
          if (accept) begin
            cmd_r             <= cmd_t'(in_cmd);
            id_r              <= in_thread_id;
            lvl_r             <= top_lvl;
            out_found         <= 1'b0;
            out_thread_out    <= '0;
            out_removed_count <= '0;
            out_overflow      <= 1'b0;
            rem_r             <= '0;
            unique case (cmd_t'(in_cmd))
              CMD_SCHEDULE: begin
                if (cnt_r[clamp_lvl] < CW'(QUEUE_DEPTH)) begin
                  cnt_r[clamp_lvl] <= cnt_r[clamp_lvl] + 1'b1;
                  pend_r           <= pend_r + 1'b1;
                end else begin
                  out_overflow <= 1'b1;
                end
                st_r <= ST_DONE;
              end
              CMD_POP: st_r <= any_q ? ST_POP : ST_DONE;
              CMD_REMOVE: begin
                lvl_r  <= '0;
                idx_r  <= '0;
                wcnt_r <= '0;
                rvld_r <= 1'b0;
                st_r   <= ST_RSCAN;
              end
              default: st_r <= ST_DONE;
            endcase
          end
        end
        ST_POP: begin
          // head read issued in idle is valid now
          out_found         <= 1'b1;
          out_thread_out    <= rdata;
          head_r[lvl_r]     <= DW'(cur_head + 1'b1);
          cnt_r[lvl_r]      <= cur_cnt - 1'b1;
          pend_r            <= pend_r - 1'b1;
          st_r              <= ST_DONE;
        end
        ST_RSCAN: begin
          // compact in place: read slot idx, write kept words at wcnt
          if (rvld_r) begin
            if (rdata == id_r) begin
              rem_r <= rem_r + 1'b1;
            end else begin
              wcnt_r <= wcnt_r + 1'b1;
            end
          end
          if (idx_r < cur_cnt) begin
            rvld_r <= 1'b1;
            idx_r  <= idx_r + 1'b1;
          end else if (!rvld_r) begin
            cnt_r[lvl_r] <= wcnt_r;
            idx_r        <= '0;
            wcnt_r       <= '0;
            if (lvl_r == LW'(LEVELS - 1)) begin
              st_r              <= ST_DONE;
              out_removed_count <= rem_r;
              pend_r            <= pend_r - rem_r;
            end else begin
              lvl_r <= lvl_r + 1'b1;
            end
          end else begin
            rvld_r <= 1'b0;
          end
        end
        ST_DONE: begin
          out_pending_count <= pend_r;
          out_valid         <= 1'b1;
          st_r              <= ST_IDLE;
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign busy = (st_r != ST_IDLE) || out_valid;

  // checks
  a_no_start_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ST_IDLE) |-> busy) else $error("busy low while working");
  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DONE) |=> out_valid) else $error("missing result strobe");
  a_pop_found: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_POP) |=> ##1 (out_valid && out_found)) else $error("pop lost");
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 7'(LEVELS * QUEUE_DEPTH)) else $error("pending overflow");

endmodule
